FILE: rtl/core/nfc_response_frame_parser_defines.svh
// ---------------------------------------------------------------------------
// NFC response frame parser assertion macros
// Shared concurrent assertion forms for the response frame parser.
// ---------------------------------------------------------------------------
`ifndef NFC_RESPONSE_FRAME_PARSER_DEFINES_SVH
`define NFC_RESPONSE_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFC_RFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NFC_RFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nfc_rfp_pkg.sv
// ---------------------------------------------------------------------------
// NFC response frame parser package
// Types, codes and constants shared by the response frame parser modules.
// ---------------------------------------------------------------------------
package nfc_rfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned REG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SENT_CMD  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_ID  = 2'd2;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] SENT_CMD_RST = 8'h00;
    localparam logic [BYTE_W-1:0] CAPACITY_RST = 8'hFF;
    localparam logic [BYTE_W-1:0] FRAME_ID_RST = 8'hD5;

    // Start sequence bytes.
    localparam logic [BYTE_W-1:0] PREAMBLE_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0] START_END_BYTE = 8'hFF;

    // Frame status codes.
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd3;

    typedef enum logic [9:0] {
        PH_IDLE   = 10'b00_0000_0001,
        PH_START2 = 10'b00_0000_0010,
        PH_START3 = 10'b00_0000_0100,
        PH_LEN    = 10'b00_0000_1000,
        PH_LCS    = 10'b00_0001_0000,
        PH_TFI    = 10'b00_0010_0000,
        PH_CMD    = 10'b00_0100_0000,
        PH_DATA   = 10'b00_1000_0000,
        PH_DCS    = 10'b01_0000_0000,
        PH_SKIP   = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] sent_command_code;
        logic [BYTE_W-1:0] payload_capacity;
        logic [BYTE_W-1:0] response_frame_id;
    } t_cfg;

    typedef struct packed {
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [BYTE_W-1:0]   payload_index;
        logic                frame_done;
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   payload_length;
    } t_result;

endpackage

FILE: rtl/core/nfc_rfp_if.sv
// ---------------------------------------------------------------------------
// NFC response frame parser channels
// Valid/ready channels for received bytes, parse results and register writes.
// ---------------------------------------------------------------------------
interface nfc_rfp_in_if;
    logic                           valid;
    logic                           ready;
    logic                           frame_start;
    logic [nfc_rfp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output frame_start, output rx_byte, input ready);
    modport sink   (input valid, input frame_start, input rx_byte, output ready);
endinterface

interface nfc_rfp_out_if;
    logic                             valid;
    logic                             ready;
    logic                             payload_valid;
    logic [nfc_rfp_pkg::BYTE_W-1:0]   payload_byte;
    logic [nfc_rfp_pkg::BYTE_W-1:0]   payload_index;
    logic                             frame_done;
    logic [nfc_rfp_pkg::STATUS_W-1:0] frame_status;
    logic [nfc_rfp_pkg::BYTE_W-1:0]   payload_length;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output frame_done, output frame_status, output payload_length, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_index,
        input frame_done, input frame_status, input payload_length, output ready
    );
endinterface

interface nfc_rfp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [nfc_rfp_pkg::REG_IDX_W-1:0] index;
    logic [nfc_rfp_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/nfc_rfp_cfg_regs.sv
// ---------------------------------------------------------------------------
// NFC response frame parser configuration registers
// Holds the expected command, payload capacity and frame identifier.
// ---------------------------------------------------------------------------
module nfc_rfp_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    nfc_rfp_cfg_if.sink         i_cfg,
    output nfc_rfp_pkg::t_cfg   o_cfg
);

    nfc_rfp_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sent_command_code <= nfc_rfp_pkg::SENT_CMD_RST;
            r_cfg.payload_capacity  <= nfc_rfp_pkg::CAPACITY_RST;
            r_cfg.response_frame_id <= nfc_rfp_pkg::FRAME_ID_RST;
        end else if (i_cfg.valid) begin
            // Writes to an index past the last register are dropped.
            if (i_cfg.index == nfc_rfp_pkg::REG_SENT_CMD) begin
                r_cfg.sent_command_code <= i_cfg.data;
            end
            if (i_cfg.index == nfc_rfp_pkg::REG_CAPACITY) begin
                r_cfg.payload_capacity <= i_cfg.data;
            end
            if (i_cfg.index == nfc_rfp_pkg::REG_FRAME_ID) begin
                r_cfg.response_frame_id <= i_cfg.data;
            end
        end
    end

endmodule

FILE: rtl/core/nfc_rfp_parser.sv
// ---------------------------------------------------------------------------
// NFC response frame parser state machine
// Per-byte frame parsing: header checks, payload streaming, checksum, skip.
// ---------------------------------------------------------------------------
module nfc_rfp_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic                             i_start,
    input  logic [nfc_rfp_pkg::BYTE_W-1:0]   i_byte,
    input  nfc_rfp_pkg::t_cfg                i_cfg,
    output nfc_rfp_pkg::t_result             o_result
);

    nfc_rfp_pkg::t_phase                r_phase, n_phase, w_phase;
    logic [nfc_rfp_pkg::BYTE_W-1:0]     r_hlen, n_hlen;
    logic [nfc_rfp_pkg::BYTE_W-1:0]     r_rem, n_rem;
    logic [nfc_rfp_pkg::BYTE_W-1:0]     r_sum, n_sum;
    logic [nfc_rfp_pkg::STATUS_W-1:0]   r_pend, n_pend;
    logic [nfc_rfp_pkg::BYTE_W-1:0]     w_paylen;
    logic [nfc_rfp_pkg::BYTE_W-1:0]     w_rem_dec;
    logic [nfc_rfp_pkg::BYTE_W-1:0]     w_expect_cmd;
    nfc_rfp_pkg::t_result               w_res;

    assign w_paylen     = r_hlen - 8'd2;
    assign w_expect_cmd = i_cfg.sent_command_code + 8'd1;
    // The skip counter stops at zero.
    assign w_rem_dec    = (r_rem != '0) ? (r_rem - 8'd1) : r_rem;
    // A start flag restarts parsing from the preamble, dropping any open frame.
    assign w_phase      = i_start ? nfc_rfp_pkg::PH_IDLE : r_phase;

    always_comb begin
        n_phase = r_phase;
        n_hlen  = r_hlen;
        n_rem   = r_rem;
        n_sum   = r_sum;
        n_pend  = r_pend;
        w_res   = '0;
        unique case (w_phase)
            nfc_rfp_pkg::PH_IDLE: begin
                if (i_start) begin
                    if (i_byte == nfc_rfp_pkg::PREAMBLE_BYTE) begin
                        n_phase = nfc_rfp_pkg::PH_START2;
                    end else begin
                        w_res.frame_done   = 1'b1;
                        w_res.frame_status = nfc_rfp_pkg::ST_INVALID;
                        n_phase            = nfc_rfp_pkg::PH_IDLE;
                    end
                end
            end
            nfc_rfp_pkg::PH_START2: begin
                if (i_byte == nfc_rfp_pkg::PREAMBLE_BYTE) begin
                    n_phase = nfc_rfp_pkg::PH_START3;
                end else begin
                    w_res.frame_done   = 1'b1;
                    w_res.frame_status = nfc_rfp_pkg::ST_INVALID;
                    n_phase            = nfc_rfp_pkg::PH_IDLE;
                end
            end
            nfc_rfp_pkg::PH_START3: begin
                if (i_byte == nfc_rfp_pkg::START_END_BYTE) begin
                    n_phase = nfc_rfp_pkg::PH_LEN;
                end else begin
                    w_res.frame_done   = 1'b1;
                    w_res.frame_status = nfc_rfp_pkg::ST_INVALID;
                    n_phase            = nfc_rfp_pkg::PH_IDLE;
                end
            end
            nfc_rfp_pkg::PH_LEN: begin
                n_hlen  = i_byte;
                n_phase = nfc_rfp_pkg::PH_LCS;
            end
            nfc_rfp_pkg::PH_LCS: begin
                // A length below two cannot hold the identifier and response code.
                if ((r_hlen + i_byte) != '0 || r_hlen < 8'd2) begin
                    w_res.frame_done   = 1'b1;
                    w_res.frame_status = nfc_rfp_pkg::ST_INVALID;
                    n_phase            = nfc_rfp_pkg::PH_IDLE;
                end else begin
                    n_phase = nfc_rfp_pkg::PH_TFI;
                end
            end
            nfc_rfp_pkg::PH_TFI: begin
                if (i_byte == i_cfg.response_frame_id) begin
                    n_phase = nfc_rfp_pkg::PH_CMD;
                end else begin
                    w_res.frame_done   = 1'b1;
                    w_res.frame_status = nfc_rfp_pkg::ST_INVALID;
                    n_phase            = nfc_rfp_pkg::PH_IDLE;
                end
            end
            nfc_rfp_pkg::PH_CMD: begin
                if (i_byte != w_expect_cmd) begin
                    w_res.frame_done   = 1'b1;
                    w_res.frame_status = nfc_rfp_pkg::ST_INVALID;
                    n_phase            = nfc_rfp_pkg::PH_IDLE;
                end else if (w_paylen > i_cfg.payload_capacity) begin
                    // Skip payload, data checksum and postamble unchecked.
                    n_pend  = nfc_rfp_pkg::ST_NOSPACE;
                    n_rem   = w_paylen + 8'd2;
                    n_phase = nfc_rfp_pkg::PH_SKIP;
                end else begin
                    n_sum   = i_cfg.response_frame_id + i_byte;
                    n_rem   = w_paylen;
                    n_phase = (w_paylen == '0) ? nfc_rfp_pkg::PH_DCS : nfc_rfp_pkg::PH_DATA;
                end
            end
            nfc_rfp_pkg::PH_DATA: begin
                w_res.payload_valid = 1'b1;
                w_res.payload_byte  = i_byte;
                w_res.payload_index = w_paylen - r_rem;
                n_sum               = r_sum + i_byte;
                n_rem               = r_rem - 8'd1;
                if (r_rem == 8'd1) begin
                    n_phase = nfc_rfp_pkg::PH_DCS;
                end
            end
            nfc_rfp_pkg::PH_DCS: begin
                if ((r_sum + i_byte) != '0) begin
                    w_res.frame_done   = 1'b1;
                    w_res.frame_status = nfc_rfp_pkg::ST_INVALID;
                    n_phase            = nfc_rfp_pkg::PH_IDLE;
                end else begin
                    // Only the postamble is left to read.
                    n_pend  = nfc_rfp_pkg::ST_OK;
                    n_rem   = 8'd1;
                    n_phase = nfc_rfp_pkg::PH_SKIP;
                end
            end
            nfc_rfp_pkg::PH_SKIP: begin
                n_rem = w_rem_dec;
                if (w_rem_dec == '0) begin
                    w_res.frame_done = 1'b1;
                    if (r_pend == nfc_rfp_pkg::ST_BUSY) begin
                        w_res.frame_status = nfc_rfp_pkg::ST_INVALID;
                    end else begin
                        w_res.frame_status = r_pend;
                    end
                    if (r_pend == nfc_rfp_pkg::ST_OK) begin
                        w_res.payload_length = w_paylen;
                    end
                    n_phase = nfc_rfp_pkg::PH_IDLE;
                end
            end
            default: begin
                // A corrupted phase code behaves as idle.
                n_phase = nfc_rfp_pkg::PH_IDLE;
            end
        endcase
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nfc_rfp_pkg::PH_IDLE;
            r_hlen  <= '0;
            r_rem   <= '0;
            r_sum   <= '0;
            r_pend  <= nfc_rfp_pkg::ST_BUSY;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_hlen  <= n_hlen;
            r_rem   <= n_rem;
            r_sum   <= n_sum;
            r_pend  <= n_pend;
        end
    end

endmodule

FILE: rtl/core/nfc_response_frame_parser.sv
// ---------------------------------------------------------------------------
// NFC response frame parser
// Parses a controller's normal information frame one received byte per
// request and returns exactly one result per byte. A byte flagged with
// frame_start opens a frame; the parser checks the 00 00 FF start sequence,
// the length against its checksum, the frame identifier and the response code
// (sent command plus one), streams the payload bytes out with their index,
// checks the data checksum and reads the postamble. Frames whose payload is
// larger than payload_capacity are skipped and end with status no space; on
// any error the parser waits for the next frame_start. The block takes one
// byte every clock cycle while the result side does not stall; a byte passes
// through the input register and then the result register, and the frame state
// is updated as its result is registered. Configuration writes are always
// accepted and must only be issued while no byte is in flight.
// ---------------------------------------------------------------------------
`include "nfc_response_frame_parser_defines.svh"

module nfc_response_frame_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    nfc_rfp_in_if.sink      i_in,
    nfc_rfp_cfg_if.sink     i_cfg,
    nfc_rfp_out_if.source   o_out
);

    logic                              r_in_valid;
    logic                              r_in_start;
    logic [nfc_rfp_pkg::BYTE_W-1:0]    r_in_byte;
    logic                              r_out_valid;
    nfc_rfp_pkg::t_result              r_res;
    nfc_rfp_pkg::t_result              w_res;
    nfc_rfp_pkg::t_cfg                 w_cfg;
    logic                              w_out_free;
    logic                              w_advance;
    logic                              w_in_take;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;
    assign w_in_take  = i_in.valid && i_in.ready;

    nfc_rfp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    nfc_rfp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_start   (r_in_start),
        .i_byte    (r_in_byte),
        .i_cfg     (w_cfg),
        .o_result  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_take || (r_in_valid && !w_advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_start <= i_in.frame_start;
            r_in_byte  <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.payload_valid  = r_res.payload_valid;
    assign o_out.payload_byte   = r_res.payload_byte;
    assign o_out.payload_index  = r_res.payload_index;
    assign o_out.frame_done     = r_res.frame_done;
    assign o_out.frame_status   = r_res.frame_status;
    assign o_out.payload_length = r_res.payload_length;

    // A payload byte never ends a frame.
    `NFC_RFP_ASSERT_NOW(a_payload_not_done, i_clk, i_rst_n, r_out_valid && r_res.payload_valid, !r_res.frame_done, "payload byte reported together with frame end")
    // Status is only reported on the byte that ends a frame.
    `NFC_RFP_ASSERT_NOW(a_status_only_on_done, i_clk, i_rst_n, r_out_valid && !r_res.frame_done, r_res.frame_status == nfc_rfp_pkg::ST_BUSY, "frame status set without frame end")
    // A length is only reported for a successful frame.
    `NFC_RFP_ASSERT_NOW(a_length_only_on_ok, i_clk, i_rst_n, r_out_valid && (r_res.payload_length != '0), r_res.frame_done && (r_res.frame_status == nfc_rfp_pkg::ST_OK), "payload length outside a good frame end")
    // A held input byte is not lost or overwritten while the result side stalls.
    `NFC_RFP_ASSERT_NEXT(a_in_reg_holds, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid && $stable(r_in_byte) && $stable(r_in_start), "input register changed while stalled")

endmodule

FILE: dv/nfc_response_frame_parser_checker.sv
// ---------------------------------------------------------------------------
// NFC response frame parser checker
// Watches the byte, register and result channels of the parser. It keeps its
// own copy of the register settings and of the frame parse state, predicts
// the result of every accepted byte and compares each returned result, field
// by field, with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module nfc_response_frame_parser_checker
    import nfc_rfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    nfc_rfp_in_if   i_in_ch,
    nfc_rfp_cfg_if  i_cfg_ch,
    nfc_rfp_out_if  i_out_ch,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_checked,
    output int      o_ok_frames,
    output int      o_nospace_frames,
    output int      o_invalid_frames
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTS = 30;

    // Register copies.
    logic [BYTE_W-1:0] cfg_sent_cmd;
    logic [BYTE_W-1:0] cfg_capacity;
    logic [BYTE_W-1:0] cfg_frame_id;

    // Frame parse state.
    t_phase              parse_state;
    logic [BYTE_W-1:0]   hdr_len;
    logic [BYTE_W-1:0]   bytes_left;
    logic [BYTE_W-1:0]   run_sum;
    logic [STATUS_W-1:0] pend_status;

    t_result expected_results[$];

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_checked        = 0;
        o_ok_frames      = 0;
        o_nospace_frames = 0;
        o_invalid_frames = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTS) begin
            $display("[%0t] parser mismatch on %s: got %0d, expected %0d",
                     $time, what, got, want);
        end
    endtask

    function automatic t_result parse_rx_byte(input logic start, input logic [BYTE_W-1:0] b);
        t_result           r;
        t_phase            ph;
        logic [BYTE_W-1:0] plen;
        logic [BYTE_W-1:0] chk;
        logic              bad;
        r    = '0;
        bad  = 1'b0;
        plen = hdr_len - 8'd2;
        // A flagged byte always throws away whatever frame was in progress.
        ph   = start ? PH_IDLE : parse_state;
        case (ph)
            PH_START2: begin
                if (b == PREAMBLE_BYTE) parse_state = PH_START3;
                else bad = 1'b1;
            end
            PH_START3: begin
                if (b == START_END_BYTE) parse_state = PH_LEN;
                else bad = 1'b1;
            end
            PH_LEN: begin
                hdr_len     = b;
                parse_state = PH_LCS;
            end
            PH_LCS: begin
                chk = hdr_len + b;
                if (chk != 8'h00 || hdr_len < 8'd2) bad = 1'b1;
                else parse_state = PH_TFI;
            end
            PH_TFI: begin
                if (b == cfg_frame_id) parse_state = PH_CMD;
                else bad = 1'b1;
            end
            PH_CMD: begin
                chk = cfg_sent_cmd + 8'd1;
                if (b != chk) begin
                    bad = 1'b1;
                end else if (plen > cfg_capacity) begin
                    // Payload, checksum and postamble all go by unchecked.
                    pend_status = ST_NOSPACE;
                    bytes_left  = plen + 8'd2;
                    parse_state = PH_SKIP;
                end else begin
                    run_sum     = cfg_frame_id + b;
                    bytes_left  = plen;
                    parse_state = (plen == 8'd0) ? PH_DCS : PH_DATA;
                end
            end
            PH_DATA: begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = plen - bytes_left;
                run_sum         = run_sum + b;
                bytes_left      = bytes_left - 8'd1;
                if (bytes_left == 8'd0) parse_state = PH_DCS;
            end
            PH_DCS: begin
                chk = run_sum + b;
                if (chk != 8'h00) begin
                    bad = 1'b1;
                end else begin
                    pend_status = ST_OK;
                    bytes_left  = 8'd1;
                    parse_state = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (bytes_left != 8'd0) bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    r.frame_done   = 1'b1;
                    r.frame_status = (pend_status == ST_BUSY) ? ST_INVALID : pend_status;
                    if (pend_status == ST_OK) r.payload_length = plen;
                    parse_state    = PH_IDLE;
                end
            end
            default: begin
                // Idle: only a flagged byte opens a frame, and it must be a zero.
                if (start) begin
                    if (b == PREAMBLE_BYTE) parse_state = PH_START2;
                    else bad = 1'b1;
                end
            end
        endcase
        if (bad) begin
            r.frame_done   = 1'b1;
            r.frame_status = ST_INVALID;
            parse_state    = PH_IDLE;
        end
        return r;
    endfunction

    task automatic check_result(input t_result want);
        if (i_out_ch.payload_valid !== want.payload_valid)
            report_mismatch("payload_valid", i_out_ch.payload_valid, want.payload_valid);
        if (i_out_ch.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", i_out_ch.payload_byte, want.payload_byte);
        if (i_out_ch.payload_index !== want.payload_index)
            report_mismatch("payload_index", i_out_ch.payload_index, want.payload_index);
        if (i_out_ch.frame_done !== want.frame_done)
            report_mismatch("frame_done", i_out_ch.frame_done, want.frame_done);
        if (i_out_ch.frame_status !== want.frame_status)
            report_mismatch("frame_status", i_out_ch.frame_status, want.frame_status);
        if (i_out_ch.payload_length !== want.payload_length)
            report_mismatch("payload_length", i_out_ch.payload_length, want.payload_length);
        if (want.frame_done) begin
            case (want.frame_status)
                ST_OK:      o_ok_frames++;
                ST_NOSPACE: o_nospace_frames++;
                default:    o_invalid_frames++;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_sent_cmd = SENT_CMD_RST;
            cfg_capacity = CAPACITY_RST;
            cfg_frame_id = FRAME_ID_RST;
            parse_state  = PH_IDLE;
            hdr_len      = '0;
            bytes_left   = '0;
            run_sum      = '0;
            pend_status  = ST_BUSY;
            expected_results.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                expected_results.push_back(parse_rx_byte(i_in_ch.frame_start, i_in_ch.rx_byte));
            end
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                case (i_cfg_ch.index)
                    REG_SENT_CMD: cfg_sent_cmd = i_cfg_ch.data;
                    REG_CAPACITY: cfg_capacity = i_cfg_ch.data;
                    REG_FRAME_ID: cfg_frame_id = i_cfg_ch.data;
                    default: ;
                endcase
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request waiting", 1, 0);
                end else begin
                    check_result(expected_results.pop_front());
                    o_checked++;
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: dv/nfc_response_frame_parser_tb.sv
// ---------------------------------------------------------------------------
// NFC response frame parser testbench
// Sends well-formed and broken response frames, stray bytes and restarts to
// the parser under several register settings and idling patterns, including
// a long hold on the result side, and lets the checker compare every result.
// ---------------------------------------------------------------------------
module nfc_response_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nfc_rfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {
        FL_NONE, FL_PRE0, FL_PRE1, FL_PRE2, FL_LCS, FL_SHORT, FL_TFI, FL_CMD, FL_DCS, FL_TRUNC
    } t_flaw;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    nfc_rfp_in_if  in_if();
    nfc_rfp_out_if out_if();
    nfc_rfp_cfg_if cfg_if();

    int chk_fail;
    int chk_pending;
    int chk_checked;
    int chk_ok;
    int chk_nospace;
    int chk_invalid;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_req     = 0;

    int bytes_sent     = 0;
    int frame_bytes    = 0;
    int frames_sent    = 0;
    int settings_count = 0;

    logic [BYTE_W-1:0] cur_sent_cmd = SENT_CMD_RST;
    logic [BYTE_W-1:0] cur_capacity = CAPACITY_RST;
    logic [BYTE_W-1:0] cur_frame_id = FRAME_ID_RST;

    nfc_response_frame_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    nfc_response_frame_parser_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_ch          (in_if),
        .i_cfg_ch         (cfg_if),
        .i_out_ch         (out_if),
        .o_fail_count     (chk_fail),
        .o_pending        (chk_pending),
        .o_checked        (chk_checked),
        .o_ok_frames      (chk_ok),
        .o_nospace_frames (chk_nospace),
        .o_invalid_frames (chk_invalid)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] rand_nonzero();
        return 8'($urandom_range(255, 1));
    endfunction

    // Called and returns at a falling edge; valid stays high between requests.
    task automatic put_byte(input logic start, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.frame_start <= start;
        in_if.rx_byte     <= b;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(negedge clk);
        while (chk_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_settings(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] cap,
                                  input logic [BYTE_W-1:0] fid);
        write_reg(REG_SENT_CMD, cmd);
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_FRAME_ID, fid);
        cfg_if.valid <= 1'b0;
        cur_sent_cmd = cmd;
        cur_capacity = cap;
        cur_frame_id = fid;
        settings_count++;
    endtask

    task automatic send_frame(input int paylen, input t_flaw flaw);
        logic [8:0]        seq[$];
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] lcs;
        logic [BYTE_W-1:0] tfi;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] dcs;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] pb;
        int                flaw_pos;
        len = (flaw == FL_SHORT) ? 8'($urandom_range(1)) : 8'(paylen + 2);
        lcs = -len;
        if (flaw == FL_LCS) lcs = lcs + rand_nonzero();
        tfi = cur_frame_id;
        cmd = cur_sent_cmd + 8'd1;
        sum = tfi + cmd;
        if (flaw == FL_TFI) tfi = tfi + rand_nonzero();
        if (flaw == FL_CMD) cmd = cmd + rand_nonzero();
        seq.push_back({1'b1, (flaw == FL_PRE0) ? rand_nonzero() : PREAMBLE_BYTE});
        seq.push_back({1'b0, (flaw == FL_PRE1) ? rand_nonzero() : PREAMBLE_BYTE});
        seq.push_back({1'b0, (flaw == FL_PRE2) ? 8'($urandom_range(254)) : START_END_BYTE});
        seq.push_back({1'b0, len});
        seq.push_back({1'b0, lcs});
        seq.push_back({1'b0, tfi});
        seq.push_back({1'b0, cmd});
        for (int k = 0; k < paylen; k++) begin
            pb  = 8'($urandom);
            sum = sum + pb;
            seq.push_back({1'b0, pb});
        end
        dcs = -sum;
        if (flaw == FL_DCS) dcs = dcs + rand_nonzero();
        seq.push_back({1'b0, dcs});
        seq.push_back({1'b0, 8'($urandom)});

        case (flaw)
            FL_PRE0:          flaw_pos = 0;
            FL_PRE1:          flaw_pos = 1;
            FL_PRE2:          flaw_pos = 2;
            FL_LCS, FL_SHORT: flaw_pos = 4;
            FL_TFI:           flaw_pos = 5;
            FL_CMD:           flaw_pos = 6;
            FL_TRUNC:         flaw_pos = $urandom_range(seq.size() - 2, 0);
            default:          flaw_pos = seq.size() - 1;
        endcase
        // Truncated frames and half of the other broken frames stop at the bad byte;
        // the others trail bytes that the parser has to drop until the next frame start.
        if (flaw == FL_TRUNC || $urandom_range(1) == 1) begin
            while (seq.size() > flaw_pos + 1) void'(seq.pop_back());
        end

        frames_sent++;
        frame_bytes += seq.size();
        foreach (seq[k]) put_byte(seq[k][8], seq[k][7:0]);
    endtask

    task automatic random_frames(input int n_bytes);
        int    goal;
        int    pick;
        int    plen;
        t_flaw flaw;
        goal = frame_bytes + n_bytes;
        while (frame_bytes < goal) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(3, 1)) put_byte(1'b0, 8'($urandom));
            end else if (pick < 11) begin
                put_byte(1'b1, 8'($urandom));
            end
            plen = ($urandom_range(29) == 0) ? $urandom_range(253, 20) : $urandom_range(8);
            flaw = ($urandom_range(99) < 55) ? FL_NONE : t_flaw'($urandom_range(FL_TRUNC, FL_PRE0));
            send_frame(plen, flaw);
        end
    endtask

    task automatic run_segment(input int src_pct, input int snk_pct,
                               input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] cap,
                               input logic [BYTE_W-1:0] fid, input int n_bytes,
                               input bit squeeze);
        drain();
        write_settings(cmd, cap, fid);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        // The sender keeps going while results are held back, so the parser fills up.
        if (squeeze) hold_req = HOLD_CYCLES;
        random_frames(n_bytes);
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        in_if.valid       = 1'b0;
        in_if.frame_start = 1'b0;
        in_if.rx_byte     = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = REG_SENT_CMD;
        cfg_if.data       = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset register values.
        put_byte(1'b0, 8'hFF);
        put_byte(1'b0, 8'h00);
        send_frame(0, FL_PRE0);
        send_frame(0, FL_SHORT);
        send_frame(0, FL_NONE);
        send_frame(1, FL_TRUNC);
        send_frame(1, FL_DCS);
        send_frame(2, FL_NONE);

        // A write to the unused register index must leave the settings alone.
        drain();
        write_reg(REG_SPARE, 8'($urandom));
        cfg_if.valid <= 1'b0;
        send_frame(3, FL_NONE);

        run_segment(15, 82, 8'($urandom), 8'($urandom_range(12)), 8'($urandom), 105, 1'b0);
        run_segment(82, 15, 8'hFF, 8'h00, 8'h00, 105, 1'b0);
        run_segment(0, 0, 8'h00, 8'hFF, 8'hFF, 105, 1'b1);

        drain();
        repeat (8) @(negedge clk);

        $display("Sent %0d bytes (%0d in %0d frames) under %0d register settings,",
                 bytes_sent, frame_bytes, frames_sent, settings_count);
        $display("and checked %0d results: %0d frames ok, %0d no space, %0d invalid.",
                 chk_checked, chk_ok, chk_nospace, chk_invalid);
        if (chk_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: nfc_response_frame_parser.f
+incdir+rtl/core
rtl/core/nfc_rfp_pkg.sv
rtl/core/nfc_rfp_if.sv
rtl/core/nfc_rfp_cfg_regs.sv
rtl/core/nfc_rfp_parser.sv
rtl/core/nfc_response_frame_parser.sv
dv/nfc_response_frame_parser_checker.sv
dv/nfc_response_frame_parser_tb.sv
